>>> sv/ldlp_pkg.sv
package ldlp_pkg;

  localparam int MAX_LINKS   = 8;
  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int CFG_W       = 4;
  localparam int RTT_W       = 32;
  localparam int BW_W        = 16;
  localparam int FLT_W       = 32;
  localparam int PEND_W      = 40;
  localparam int SIZE_W      = 16;
  localparam int KEY_W       = 48;
  localparam int PROD_W      = RTT_W + CFG_W;
  localparam int DIVD_W      = PEND_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIVD_W);

  localparam logic [1:0] CMD_STATS     = 2'd0;
  localparam logic [1:0] CMD_ASSIGN    = 2'd1;
  localparam logic [1:0] CMD_SEND_DONE = 2'd2;

  localparam logic [0:0] CFG_RTT_WEIGHT   = 1'b0;
  localparam logic [0:0] CFG_LINKS_IN_USE = 1'b1;

  localparam logic [CFG_W-1:0]  RTT_WEIGHT_RST = CFG_W'(2);
  localparam logic [KEY_W-1:0]  KEY_MAX        = '1;
  localparam logic [PEND_W-1:0] PEND_MAX       = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND_RD,
    ST_SCAN_RD,
    ST_DIV,
    ST_KEY,
    ST_ASSIGN_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [RTT_W-1:0] rtt;
    logic [BW_W-1:0]  bw;
    logic [FLT_W-1:0] flight;
  } link_stats_t;

endpackage

>>> sv/ldlp_req_if.sv
interface ldlp_req_if import ldlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [IDX_W-1:0]  link_index;
  logic [RTT_W-1:0]  rtt_value;
  logic [BW_W-1:0]   bandwidth_value;
  logic [FLT_W-1:0]  in_flight_bytes;
  logic [SIZE_W-1:0] pkt_bytes;

  modport source (
    output valid, command, link_index, rtt_value, bandwidth_value, in_flight_bytes,
           pkt_bytes,
    input  ready
  );
  modport sink (
    input  valid, command, link_index, rtt_value, bandwidth_value, in_flight_bytes,
           pkt_bytes,
    output ready
  );
endinterface

>>> sv/ldlp_rsp_if.sv
interface ldlp_rsp_if import ldlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             assigned;
  logic [IDX_W-1:0] chosen_link;
  logic [KEY_W-1:0] chosen_key;

  modport source (
    output valid, assigned, chosen_link, chosen_key,
    input  ready
  );
  modport sink (
    input  valid, assigned, chosen_link, chosen_key,
    output ready
  );
endinterface

>>> sv/least_delay_link_picker_unit.sv
// One beat is worked on at a time. An assign beat visits each active link in turn and runs
// the shared divider only for a link with nonzero bandwidth; with no active link it goes
// straight to its result. The divider retires one quotient bit per cycle.
// Synchronous reset sets rtt_weight to 2, links_in_use to 0 and marks every table entry
// unwritten, so that it reads as zero; no clearing pass is needed.
module least_delay_link_picker_unit import ldlp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  ldlp_req_if.sink         req,
  ldlp_rsp_if.source       rsp
);

  state_t state, state_next;

  logic [CFG_W-1:0] rtt_weight;
  logic [CNT_W-1:0] links_in_use;
  logic [CNT_W-1:0] n_eff;

  link_stats_t       stats_mem [TABLE_DEPTH];
  logic [PEND_W-1:0] pend_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stats_vld;
  logic [TABLE_DEPTH-1:0] pend_vld;

  logic [IDX_W-1:0]  rd_addr;
  link_stats_t       stats_rd, stats_q;
  logic [PEND_W-1:0] pend_rd, pend_q;
  logic              stats_rd_vld, pend_rd_vld;

  logic              accept, idx_ok, stats_we, pend_we, last_link, out_free;
  logic [IDX_W-1:0]  pend_wr_addr;
  logic [PEND_W-1:0] pend_wr_data;
  logic [PEND_W:0]   pend_sum;

  logic [1:0]        cmd;
  logic [IDX_W-1:0]  idx;
  logic [SIZE_W-1:0] size;
  logic              cmd_ok;
  logic              res_assigned;

  logic [IDX_W-1:0]     scan_idx;
  logic [PROD_W-1:0]    prod;
  logic [BW_W-1:0]      bw;
  logic [DIVD_W-1:0]    divd;
  logic [BW_W-1:0]      rem;
  logic [BW_W:0]        rem_shift;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PEND_W-1:0]    pend_cur;
  logic [KEY_W-1:0]     key_cur;

  logic [IDX_W-1:0]  best_idx;
  logic [KEY_W-1:0]  best_key;
  logic [PEND_W-1:0] best_pend;

  logic             rsp_valid;
  logic             rsp_assigned;
  logic [IDX_W-1:0] rsp_link;
  logic [KEY_W-1:0] rsp_key;

  always_comb begin
    if (int'(links_in_use) > MAX_LINKS) begin
      n_eff = CNT_W'(MAX_LINKS);
    end else begin
      n_eff = links_in_use;
    end
    if (int'(n_eff) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end
  end

  assign stats_q   = stats_rd_vld ? stats_rd : '0;
  assign pend_q    = pend_rd_vld ? pend_rd : '0;
  assign idx_ok    = int'(req.link_index) < MAX_LINKS;
  assign last_link = (CNT_W'(scan_idx) + CNT_W'(1)) >= n_eff;
  assign out_free  = !rsp_valid || rsp.ready;
  assign rem_shift = {rem, divd[DIVD_W-1]};
  assign key_cur   = (bw == '0) ? KEY_MAX : KEY_W'(prod) + KEY_W'(divd);
  assign pend_sum  = {1'b0, best_pend} + (PEND_W + 1)'(size);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (req.command)
            CMD_SEND_DONE: state_next = ST_PEND_RD;
            CMD_ASSIGN:    state_next = (n_eff == '0) ? ST_FINISH : ST_SCAN_RD;
            default:       state_next = ST_FINISH;
          endcase
        end
      end
      ST_PEND_RD:   state_next = ST_FINISH;
      ST_SCAN_RD:   state_next = (stats_q.bw == '0) ? ST_KEY : ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          state_next = ST_KEY;
        end
      end
      ST_KEY:       state_next = last_link ? ST_ASSIGN_WR : ST_SCAN_RD;
      ST_ASSIGN_WR: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready    = (state == ST_IDLE);
    accept       = req.valid && (state == ST_IDLE);
    stats_we     = accept && (req.command == CMD_STATS) && idx_ok;
    pend_we      = 1'b0;
    pend_wr_addr = idx;
    pend_wr_data = '0;
    rd_addr      = scan_idx;
    unique case (state)
      ST_IDLE: begin
        rd_addr = (req.command == CMD_ASSIGN) ? '0 : req.link_index;
      end
      ST_PEND_RD: begin
        pend_we      = cmd_ok;
        pend_wr_data = (pend_q >= PEND_W'(size)) ? pend_q - PEND_W'(size) : '0;
      end
      ST_KEY: begin
        rd_addr = scan_idx + IDX_W'(1);
      end
      ST_ASSIGN_WR: begin
        pend_we      = 1'b1;
        pend_wr_addr = best_idx;
        pend_wr_data = (pend_sum > (PEND_W + 1)'(PEND_MAX)) ? PEND_MAX : pend_sum[PEND_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stats_we) begin
      stats_mem[req.link_index] <= '{rtt: req.rtt_value, bw: req.bandwidth_value,
                                     flight: req.in_flight_bytes};
    end
    stats_rd <= stats_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wr_addr] <= pend_wr_data;
    end
    pend_rd <= pend_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rtt_weight   <= RTT_WEIGHT_RST;
      links_in_use <= '0;
      stats_vld    <= '0;
      pend_vld     <= '0;
      stats_rd_vld <= 1'b0;
      pend_rd_vld  <= 1'b0;
      res_assigned <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      stats_rd_vld <= stats_vld[rd_addr];
      pend_rd_vld  <= pend_vld[rd_addr];
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RTT_WEIGHT:   rtt_weight   <= cfg_data;
          CFG_LINKS_IN_USE: links_in_use <= cfg_data;
          default: begin
          end
        endcase
      end
      if (stats_we) begin
        stats_vld[req.link_index] <= 1'b1;
      end
      if (pend_we) begin
        pend_vld[pend_wr_addr] <= 1'b1;
      end
      if (accept) begin
        res_assigned <= 1'b0;
      end else if (state == ST_ASSIGN_WR) begin
        res_assigned <= 1'b1;
      end
      if (state == ST_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= req.command;
      idx      <= req.link_index;
      size     <= req.pkt_bytes;
      cmd_ok   <= idx_ok;
      scan_idx <= '0;
    end
    unique case (state)
      ST_SCAN_RD: begin
        prod     <= PROD_W'(stats_q.rtt) * PROD_W'(rtt_weight);
        divd     <= DIVD_W'(stats_q.flight) + DIVD_W'(pend_q);
        bw       <= stats_q.bw;
        rem      <= '0;
        div_cnt  <= '0;
        pend_cur <= pend_q;
      end
      ST_DIV: begin
        if (rem_shift >= {1'b0, bw}) begin
          rem  <= BW_W'(rem_shift - {1'b0, bw});
          divd <= {divd[DIVD_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift[BW_W-1:0];
          divd <= {divd[DIVD_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ST_KEY: begin
        if (scan_idx == '0 || key_cur < best_key) begin
          best_idx  <= scan_idx;
          best_key  <= key_cur;
          best_pend <= pend_cur;
        end
        scan_idx <= scan_idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
    if (state == ST_FINISH && out_free) begin
      rsp_assigned <= res_assigned && (cmd == CMD_ASSIGN);
      rsp_link     <= res_assigned ? best_idx : '0;
      rsp_key      <= res_assigned ? best_key : '0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.assigned    = rsp_assigned;
  assign rsp.chosen_link = rsp_link;
  assign rsp.chosen_key  = rsp_key;

endmodule

>>> sv/ldlp_checker.sv
module ldlp_checker import ldlp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             rsp_assigned,
  input logic [IDX_W-1:0] rsp_chosen_link,
  input logic [KEY_W-1:0] rsp_chosen_key
);

  // The block works on one beat at a time, so it cannot take two in a row.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on two consecutive cycles");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_assigned |-> rsp_chosen_link == '0 && rsp_chosen_key == '0)
    else $error("unassigned result carries a link or key");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_chosen_key) && $stable(rsp_chosen_link))
    else $error("result changed while stalled");

endmodule

bind least_delay_link_picker_unit ldlp_checker u_ldlp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_assigned    (rsp.assigned),
  .rsp_chosen_link (rsp.chosen_link),
  .rsp_chosen_key  (rsp.chosen_key)
);

>>> bench/tb_least_delay_link_picker_unit.sv
`timescale 1ns / 1ps

module tb_least_delay_link_picker_unit;
  import ldlp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 410;

  typedef struct {
    logic [1:0]        command;
    logic [IDX_W-1:0]  link;
    logic [RTT_W-1:0]  rtt;
    logic [BW_W-1:0]   bw;
    logic [FLT_W-1:0]  flight;
    logic [SIZE_W-1:0] size;
  } link_cmd_t;

  typedef struct {
    logic             assigned;
    logic [IDX_W-1:0] link;
    logic [KEY_W-1:0] key;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ldlp_req_if req();
  ldlp_rsp_if rsp();

  least_delay_link_picker_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req),
    .rsp(rsp)
  );

  logic [CFG_W-1:0]  model_weight;
  logic [CFG_W-1:0]  model_links;
  logic [RTT_W-1:0]  model_rtt [TABLE_DEPTH];
  logic [BW_W-1:0]   model_bw [TABLE_DEPTH];
  logic [FLT_W-1:0]  model_flight [TABLE_DEPTH];
  logic [PEND_W-1:0] model_pend [TABLE_DEPTH];

  pick_t expected_picks[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #5 clk = ~clk;

  function automatic logic [63:0] link_key(input int i);
    logic [63:0] k;
    if (model_bw[i] == '0) return 64'(KEY_MAX);
    k = 64'(model_rtt[i]) * 64'(model_weight)
        + (64'(model_flight[i]) + 64'(model_pend[i])) / 64'(model_bw[i]);
    return (k > 64'(KEY_MAX)) ? 64'(KEY_MAX) : k;
  endfunction

  function automatic pick_t predict_pick(input link_cmd_t c);
    pick_t p;
    int n;
    int best;
    logic [63:0] k;
    logic [63:0] best_key;
    logic [63:0] total;
    p = '{assigned: 1'b0, link: '0, key: '0};
    case (c.command)
      CMD_STATS: begin
        if (c.link < MAX_LINKS) begin
          model_rtt[c.link] = c.rtt;
          model_bw[c.link] = c.bw;
          model_flight[c.link] = c.flight;
        end
      end
      CMD_SEND_DONE: begin
        if (c.link < MAX_LINKS)
          model_pend[c.link] = (model_pend[c.link] >= PEND_W'(c.size)) ?
                               model_pend[c.link] - PEND_W'(c.size) : '0;
      end
      CMD_ASSIGN: begin
        n = (model_links > MAX_LINKS) ? MAX_LINKS : int'(model_links);
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (n != 0) begin
          best = 0;
          best_key = '0;
          for (int i = 0; i < n; i++) begin
            k = link_key(i);
            if (i == 0 || k < best_key) begin
              best = i;
              best_key = k;
            end
          end
          total = 64'(model_pend[best]) + 64'(c.size);
          model_pend[best] = (total > 64'(PEND_MAX)) ? PEND_MAX : total[PEND_W-1:0];
          p.assigned = 1'b1;
          p.link = best[IDX_W-1:0];
          p.key = best_key[KEY_W-1:0];
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic link_cmd_t make_cmd(input logic [1:0] command,
                                         input logic [IDX_W-1:0] link,
                                         input logic [RTT_W-1:0] rtt,
                                         input logic [BW_W-1:0] bw,
                                         input logic [FLT_W-1:0] flight,
                                         input logic [SIZE_W-1:0] size);
    link_cmd_t c;
    c.command = command;
    c.link = link;
    c.rtt = rtt;
    c.bw = bw;
    c.flight = flight;
    c.size = size;
    return c;
  endfunction

  function automatic logic [31:0] rand_wide();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(3);
      3, 4, 5, 6: return $urandom_range(5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [BW_W-1:0] rand_bandwidth();
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3, 4: return BW_W'($urandom_range(16, 1));
      5, 6, 7: return BW_W'($urandom_range(2000, 1));
      default: return BW_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic link_cmd_t rand_cmd();
    link_cmd_t c;
    int r;
    r = int'($urandom_range(99));
    if (r < 20) c.command = CMD_STATS;
    else if (r < 70) c.command = CMD_ASSIGN;
    else if (r < 93) c.command = CMD_SEND_DONE;
    else c.command = CMD_UNUSED;
    c.link = IDX_W'($urandom_range(7));
    c.rtt = rand_wide();
    c.bw = rand_bandwidth();
    c.flight = rand_wide();
    c.size = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(64))
                                      : SIZE_W'($urandom_range(65535));
    return c;
  endfunction

  task automatic send_cmd(input link_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= c.command;
    req.link_index <= c.link;
    req.rtt_value <= c.rtt;
    req.bandwidth_value <= c.bw;
    req.in_flight_bytes <= c.flight;
    req.pkt_bytes <= c.size;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_picks.insert(expected_picks.size(), predict_pick(c));
  endtask

  task automatic settle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_RTT_WEIGHT) model_weight = value;
    else model_links = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] weight, input logic [CFG_W-1:0] links);
    settle();
    write_reg(CFG_RTT_WEIGHT, weight);
    write_reg(CFG_LINKS_IN_USE, links);
  endtask

  task automatic test_idle_links();
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd100));
    send_cmd(make_cmd(CMD_UNUSED, 3'd6, '1, '1, '1, '1));
    send_cmd(make_cmd(CMD_SEND_DONE, 3'd3, '0, '0, '0, 16'd5));
  endtask

  task automatic test_zero_bandwidth();
    configure(RTT_WEIGHT_RST, 4'd8);
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'hFFFF));
  endtask

  task automatic test_field_extremes();
    configure(4'd15, 4'd8);
    send_cmd(make_cmd(CMD_STATS, 3'd0, '1, 16'hFFFF, '1, '0));
    send_cmd(make_cmd(CMD_STATS, 3'd7, '0, 16'd1, '1, '0));
    send_cmd(make_cmd(CMD_STATS, 3'd3, '0, 16'hFFFF, '0, '0));
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, '0));
    send_cmd(make_cmd(CMD_STATS, 3'd3, '0, '0, '0, '0));
    send_cmd(make_cmd(CMD_ASSIGN, 3'd7, '1, '1, '1, 16'd1));
  endtask

  task automatic test_ties();
    configure(4'd0, 4'd8);
    send_cmd(make_cmd(CMD_STATS, 3'd2, 32'd9, 16'd100, 32'd50, '0));
    send_cmd(make_cmd(CMD_STATS, 3'd5, 32'd7, 16'd100, 32'd50, '0));
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd60));
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd10));
  endtask

  task automatic test_send_done_floor();
    send_cmd(make_cmd(CMD_SEND_DONE, 3'd2, '0, '0, '0, 16'hFFFF));
    send_cmd(make_cmd(CMD_SEND_DONE, 3'd5, '0, '0, '0, 16'd4));
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd1));
  endtask

  task automatic test_link_clamp();
    configure(RTT_WEIGHT_RST, 4'd15);
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd7));
    configure(RTT_WEIGHT_RST, 4'd1);
    send_cmd(make_cmd(CMD_ASSIGN, 3'd0, '0, '0, '0, 16'd7));
  endtask

  task automatic test_random_traffic();
    int idle_set [4] = '{0, 86, 0, 12};
    int stall_set [4] = '{0, 0, 86, 12};
    logic [CFG_W-1:0] weight_set [4];
    logic [CFG_W-1:0] links_set [4];
    weight_set = '{RTT_WEIGHT_RST, 4'd0, 4'd15, CFG_W'($urandom_range(15))};
    links_set = '{4'd8, 4'd3, 4'd8, CFG_W'($urandom_range(15, 1))};
    for (int p = 0; p < 4; p++) begin
      configure(weight_set[p], links_set[p]);
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      for (int i = 0; i < TABLE_DEPTH; i++)
        send_cmd(make_cmd(CMD_STATS, IDX_W'(i), rand_wide(), rand_bandwidth(), rand_wide(),
                          SIZE_W'($urandom)));
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_cmd(rand_cmd());
    end
  endtask

  always @(negedge clk)
    rsp.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: result beat with nothing expected: assigned %0b link %0d key %0h",
                 $time, rsp.assigned, rsp.chosen_link, rsp.chosen_key);
        errors++;
      end else begin
        want = expected_picks[0];
        expected_picks.delete(0);
        if (rsp.assigned !== want.assigned) begin
          $display("%0t: assigned expected %0b actual %0b", $time, want.assigned, rsp.assigned);
          errors++;
        end
        if (rsp.chosen_link !== want.link) begin
          $display("%0t: chosen_link expected %0d actual %0d", $time, want.link,
                   rsp.chosen_link);
          errors++;
        end
        if (rsp.chosen_key !== want.key) begin
          $display("%0t: chosen_key expected %0h actual %0h", $time, want.key, rsp.chosen_key);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.command = CMD_STATS;
    req.link_index = '0;
    req.rtt_value = '0;
    req.bandwidth_value = '0;
    req.in_flight_bytes = '0;
    req.pkt_bytes = '0;
    rsp.ready = 1'b0;
    model_weight = RTT_WEIGHT_RST;
    model_links = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      model_rtt[i] = '0;
      model_bw[i] = '0;
      model_flight[i] = '0;
      model_pend[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_links();
    test_zero_bandwidth();
    test_field_extremes();
    test_ties();
    test_send_done_floor();
    test_link_clamp();
    test_random_traffic();

    settle();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
